>>> hdl/cdma_pkg.sv
// Shared widths, codes and result type of the chunked DMA channel.
`default_nettype none

package cdma_pkg;

   localparam int HOST_W    = 32;
   localparam int SOUND_W   = 20;
   localparam int COUNT_W   = 24;
   localparam int ELAPSED_W = 24;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 4;

   // operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes (byte address divided by four)
   localparam logic [1:0] REG_IRQ_ENABLE_CORE0  = 2'd0;
   localparam logic [1:0] REG_IRQ_ADDRESS_CORE0 = 2'd1;
   localparam logic [1:0] REG_IRQ_ENABLE_CORE1  = 2'd2;
   localparam logic [1:0] REG_IRQ_ADDRESS_CORE1 = 2'd3;

   typedef struct packed {
      logic               chunk_valid;
      logic               chunk_direction;
      logic [SOUND_W-1:0] chunk_sound_address;
      logic [HOST_W-1:0]  chunk_host_address;
      logic               hit_core0;
      logic               hit_core1;
      logic               channel_irq;
      logic               complete_flag;
      logic               busy_flag;
      logic               request_active;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/cdma_req_if.sv
// Input channel: start and tick beats of the chunked DMA channel.
`default_nettype none

interface cdma_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic                           transfer_direction;
   logic [cdma_pkg::HOST_W-1:0]    host_address;
   logic [cdma_pkg::COUNT_W-1:0]   word_count;
   logic [cdma_pkg::SOUND_W-1:0]   sound_start_address;
   logic [cdma_pkg::ELAPSED_W-1:0] elapsed_cycles;

   modport source (
      output valid, operation, transfer_direction, host_address, word_count,
             sound_start_address, elapsed_cycles,
      input  ready
   );
   modport sink (
      input  valid, operation, transfer_direction, host_address, word_count,
             sound_start_address, elapsed_cycles,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/cdma_rsp_if.sv
// Result channel: one status and chunk command beat per input beat.
`default_nettype none

interface cdma_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         chunk_valid;
   logic                         chunk_direction;
   logic [cdma_pkg::SOUND_W-1:0] chunk_sound_address;
   logic [cdma_pkg::HOST_W-1:0]  chunk_host_address;
   logic                         hit_core0;
   logic                         hit_core1;
   logic                         channel_irq;
   logic                         complete_flag;
   logic                         busy_flag;
   logic                         request_active;

   modport source (
      output valid, chunk_valid, chunk_direction, chunk_sound_address,
             chunk_host_address, hit_core0, hit_core1, channel_irq,
             complete_flag, busy_flag, request_active,
      input  ready
   );
   modport sink (
      input  valid, chunk_valid, chunk_direction, chunk_sound_address,
             chunk_host_address, hit_core0, hit_core1, channel_irq,
             complete_flag, busy_flag, request_active,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/chunked_dma_channel.sv
// Chunked DMA channel: transfer state, chunk step, APB registers and output skid.
//
// Every input beat (start or tick) runs one step of the channel in the cycle it is
// accepted and yields exactly one result beat, registered. One beat is taken per clock
// while req_if.ready is high: the step is a single compare against the countdown, a
// subtract and a few adds on the transfer registers. An output register plus one skid
// entry keep req_if.ready high while one result waits; it drops only when both are full
// and recovers on the cycle after the result is taken. The user must write the interrupt
// address registers over APB only while the channel is idle; this is not enforced.
`default_nettype none

module chunked_dma_channel #(
   parameter int CHUNK_WORDS = 32,
   parameter int CHUNK_DELAY = 1536
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cdma_req_if.sink                               req_if,
   cdma_rsp_if.source                             rsp_if,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [cdma_pkg::APB_ADDR_W-1:0]   paddr,
   input  wire logic [cdma_pkg::APB_DATA_W-1:0]   pwdata,
   output logic      [cdma_pkg::APB_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   localparam int HOST_W    = cdma_pkg::HOST_W;
   localparam int SOUND_W   = cdma_pkg::SOUND_W;
   localparam int COUNT_W   = cdma_pkg::COUNT_W;
   localparam int ELAPSED_W = cdma_pkg::ELAPSED_W;
   localparam int CD_W      = $clog2(CHUNK_DELAY + 1);

   // configuration
   logic               irq_enable_core0_ff;
   logic [SOUND_W-1:0] irq_address_core0_ff;
   logic               irq_enable_core1_ff;
   logic [SOUND_W-1:0] irq_address_core1_ff;
   logic               csr_write;
   logic [1:0]         csr_index;

   // transfer state
   logic               request_ff,   request_in;
   logic               direction_ff, direction_in;
   logic [COUNT_W-1:0] words_left_ff, words_left_in;
   logic [HOST_W-1:0]  host_ptr_ff,  host_ptr_in;
   logic [SOUND_W-1:0] sound_ptr_ff, sound_ptr_in;
   logic [CD_W-1:0]    countdown_ff, countdown_in;
   logic               complete_ff,  complete_in;
   logic               busy_ff,      busy_in;

   // output register and skid
   cdma_pkg::result_type out_ff, skid_ff, result_in;
   logic                 out_valid_ff, skid_valid_ff;
   logic                 accept, take;

   // step working values
   logic                 start;
   logic [ELAPSED_W-1:0] elapsed;
   logic                 cur_request, cur_direction;
   logic [COUNT_W-1:0]   cur_words;
   logic [HOST_W-1:0]    cur_host;
   logic [SOUND_W-1:0]   cur_sound;
   logic [CD_W-1:0]      cur_countdown;
   logic                 cur_complete, cur_busy;
   logic [SOUND_W:0]     window_top;
   logic [COUNT_W-1:0]   words_after;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      prdata = '0;
      case (csr_index)
         cdma_pkg::REG_IRQ_ENABLE_CORE0:  prdata[0] = irq_enable_core0_ff;
         cdma_pkg::REG_IRQ_ADDRESS_CORE0: prdata[SOUND_W-1:0] = irq_address_core0_ff;
         cdma_pkg::REG_IRQ_ENABLE_CORE1:  prdata[0] = irq_enable_core1_ff;
         cdma_pkg::REG_IRQ_ADDRESS_CORE1: prdata[SOUND_W-1:0] = irq_address_core1_ff;
         default:                         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_enable_core0_ff  <= 1'b0;
         irq_address_core0_ff <= '0;
         irq_enable_core1_ff  <= 1'b0;
         irq_address_core1_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cdma_pkg::REG_IRQ_ENABLE_CORE0:  irq_enable_core0_ff  <= pwdata[0];
            cdma_pkg::REG_IRQ_ADDRESS_CORE0: irq_address_core0_ff <= pwdata[SOUND_W-1:0];
            cdma_pkg::REG_IRQ_ENABLE_CORE1:  irq_enable_core1_ff  <= pwdata[0];
            cdma_pkg::REG_IRQ_ADDRESS_CORE1: irq_address_core1_ff <= pwdata[SOUND_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign take         = out_valid_ff && rsp_if.ready;

   // step logic
   always_comb begin
      start = (req_if.operation == cdma_pkg::OP_START);

      // a start loads the transfer and acts as zero elapsed cycles
      if (start) begin
         cur_request   = 1'b1;
         cur_direction = req_if.transfer_direction;
         cur_words     = req_if.word_count;
         cur_host      = req_if.host_address;
         cur_sound     = req_if.sound_start_address;
         cur_countdown = '0;
         cur_complete  = 1'b0;
         cur_busy      = 1'b1;
         elapsed       = '0;
      end else begin
         cur_request   = request_ff;
         cur_direction = direction_ff;
         cur_words     = words_left_ff;
         cur_host      = host_ptr_ff;
         cur_sound     = sound_ptr_ff;
         cur_countdown = countdown_ff;
         cur_complete  = complete_ff;
         cur_busy      = busy_ff;
         elapsed       = req_if.elapsed_cycles;
      end

      window_top  = {1'b0, cur_sound} + (SOUND_W+1)'(CHUNK_WORDS);
      words_after = (cur_words > COUNT_W'(CHUNK_WORDS)) ?
                    cur_words - COUNT_W'(CHUNK_WORDS) : '0;

      request_in   = cur_request;
      direction_in = cur_direction;
      words_left_in = cur_words;
      host_ptr_in  = cur_host;
      sound_ptr_in = cur_sound;
      countdown_in = cur_countdown;
      complete_in  = cur_complete;
      busy_in      = cur_busy;
      result_in    = '0;

      if (cur_request) begin
         if (cur_words == '0) begin
            complete_in = 1'b1;
            request_in  = 1'b0;
         end else if (elapsed < ELAPSED_W'(cur_countdown)) begin
            countdown_in = cur_countdown - CD_W'(elapsed);
         end else begin
            result_in.chunk_valid         = 1'b1;
            result_in.chunk_direction     = cur_direction;
            result_in.chunk_sound_address = cur_sound;
            result_in.chunk_host_address  = cur_host;
            // hit window has no wrap at the top of sound memory
            result_in.hit_core0 = irq_enable_core0_ff &&
                                  (irq_address_core0_ff >= cur_sound) &&
                                  ({1'b0, irq_address_core0_ff} < window_top);
            result_in.hit_core1 = irq_enable_core1_ff &&
                                  (irq_address_core1_ff >= cur_sound) &&
                                  ({1'b0, irq_address_core1_ff} < window_top);
            result_in.channel_irq = (words_after == '0);
            sound_ptr_in  = window_top[SOUND_W-1:0];
            host_ptr_in   = cur_host + HOST_W'(2 * CHUNK_WORDS);
            words_left_in = words_after;
            countdown_in  = CD_W'(CHUNK_DELAY);
         end
      end

      result_in.complete_flag  = complete_in;
      result_in.busy_flag      = busy_in;
      result_in.request_active = request_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_ff    <= 1'b0;
         direction_ff  <= 1'b0;
         words_left_ff <= '0;
         host_ptr_ff   <= '0;
         sound_ptr_ff  <= '0;
         countdown_ff  <= '0;
         complete_ff   <= 1'b0;
         busy_ff       <= 1'b0;
      end else if (accept) begin
         request_ff    <= request_in;
         direction_ff  <= direction_in;
         words_left_ff <= words_left_in;
         host_ptr_ff   <= host_ptr_in;
         sound_ptr_ff  <= sound_ptr_in;
         countdown_ff  <= countdown_in;
         complete_ff   <= complete_in;
         busy_ff       <= busy_in;
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   assign rsp_if.valid               = out_valid_ff;
   assign rsp_if.chunk_valid         = out_ff.chunk_valid;
   assign rsp_if.chunk_direction     = out_ff.chunk_direction;
   assign rsp_if.chunk_sound_address = out_ff.chunk_sound_address;
   assign rsp_if.chunk_host_address  = out_ff.chunk_host_address;
   assign rsp_if.hit_core0           = out_ff.hit_core0;
   assign rsp_if.hit_core1           = out_ff.hit_core1;
   assign rsp_if.channel_irq         = out_ff.channel_irq;
   assign rsp_if.complete_flag       = out_ff.complete_flag;
   assign rsp_if.busy_flag           = out_ff.busy_flag;
   assign rsp_if.request_active      = out_ff.request_active;

   // skid entry is filled only behind a held output beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat while output register is empty");

   // an accepted start always leaves the channel busy
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.operation == cdma_pkg::OP_START) |=> busy_ff)
      else $error("busy not set after start beat");

   // channel interrupt and address hits only ride on an issued chunk
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.chunk_valid) |->
         (!out_ff.channel_irq && !out_ff.hit_core0 && !out_ff.hit_core1))
      else $error("interrupt flag without a chunk command");

   // countdown never exceeds its reload value
   assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= CD_W'(CHUNK_DELAY))
      else $error("countdown above reload value");

   // a completed transfer has no pending request
   assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> !request_ff)
      else $error("complete set while request pending");

endmodule

`default_nettype wire

>>> verif/chunked_dma_channel_test.sv
// Testbench of the chunked DMA channel: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module chunked_dma_channel_test;

   localparam int CHUNK_WORDS = 32;
   localparam int CHUNK_DELAY = 1536;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 115;
   localparam int PHASES      = 6;

   localparam int HOST_W     = cdma_pkg::HOST_W;
   localparam int SOUND_W    = cdma_pkg::SOUND_W;
   localparam int COUNT_W    = cdma_pkg::COUNT_W;
   localparam int ELAPSED_W  = cdma_pkg::ELAPSED_W;
   localparam int APB_ADDR_W = cdma_pkg::APB_ADDR_W;
   localparam int APB_DATA_W = cdma_pkg::APB_DATA_W;

   typedef struct {
      logic                 operation;
      logic                 transfer_direction;
      logic [HOST_W-1:0]    host_address;
      logic [COUNT_W-1:0]   word_count;
      logic [SOUND_W-1:0]   sound_start_address;
      logic [ELAPSED_W-1:0] elapsed_cycles;
   } dma_beat_type;

   class chunk_tracker_type;
      logic                 irq_en0, irq_en1;
      logic [SOUND_W-1:0]   irq_addr0, irq_addr1;
      logic                 pending, direction, complete, busy;
      logic [COUNT_W-1:0]   words;
      logic [HOST_W-1:0]    host_ptr;
      logic [SOUND_W-1:0]   sound_ptr;
      logic [31:0]          countdown;
      cdma_pkg::result_type expected_results[$];
      int                   mismatches;

      function new();
         irq_en0 = 1'b0;
         irq_en1 = 1'b0;
         irq_addr0 = '0;
         irq_addr1 = '0;
         pending = 1'b0;
         direction = 1'b0;
         complete = 1'b0;
         busy = 1'b0;
         words = '0;
         host_ptr = '0;
         sound_ptr = '0;
         countdown = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            cdma_pkg::REG_IRQ_ENABLE_CORE0:  irq_en0 = value[0];
            cdma_pkg::REG_IRQ_ADDRESS_CORE0: irq_addr0 = value[SOUND_W-1:0];
            cdma_pkg::REG_IRQ_ENABLE_CORE1:  irq_en1 = value[0];
            cdma_pkg::REG_IRQ_ADDRESS_CORE1: irq_addr1 = value[SOUND_W-1:0];
            default: ;
         endcase
      endfunction

      // window is [base, base + CHUNK_WORDS) with no wrap at the top of memory
      function logic watch_hit(logic en, logic [SOUND_W-1:0] addr, logic [SOUND_W-1:0] base);
         return en && addr >= base && {1'b0, addr} < {1'b0, base} + (SOUND_W+1)'(CHUNK_WORDS);
      endfunction

      function void note_beat(dma_beat_type b);
         cdma_pkg::result_type r;
         logic [ELAPSED_W-1:0] elapsed;
         r = '0;
         if (b.operation == cdma_pkg::OP_START) begin
            direction = b.transfer_direction;
            host_ptr = b.host_address;
            words = b.word_count;
            sound_ptr = b.sound_start_address;
            complete = 1'b0;
            busy = 1'b1;
            countdown = '0;
            pending = 1'b1;
            elapsed = '0;
         end else begin
            elapsed = b.elapsed_cycles;
         end
         if (pending) begin
            if (words == '0) begin
               complete = 1'b1;
               pending = 1'b0;
            end else if (32'(elapsed) < countdown) begin
               countdown = countdown - 32'(elapsed);
            end else begin
               r.chunk_valid = 1'b1;
               r.chunk_direction = direction;
               r.chunk_sound_address = sound_ptr;
               r.chunk_host_address = host_ptr;
               r.hit_core0 = watch_hit(irq_en0, irq_addr0, sound_ptr);
               r.hit_core1 = watch_hit(irq_en1, irq_addr1, sound_ptr);
               sound_ptr = sound_ptr + SOUND_W'(CHUNK_WORDS);
               host_ptr = host_ptr + HOST_W'(2 * CHUNK_WORDS);
               words = (words > COUNT_W'(CHUNK_WORDS)) ? words - COUNT_W'(CHUNK_WORDS) : '0;
               r.channel_irq = (words == '0);
               countdown = 32'(CHUNK_DELAY);
            end
         end
         r.complete_flag = complete;
         r.busy_flag = busy;
         r.request_active = pending;
         expected_results.push_back(r);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      task check_result(cdma_pkg::result_type got);
         cdma_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         want = expected_results.pop_front();
         compare_field("chunk_valid", 32'(got.chunk_valid), 32'(want.chunk_valid));
         compare_field("chunk_direction", 32'(got.chunk_direction), 32'(want.chunk_direction));
         compare_field("chunk_sound_address", 32'(got.chunk_sound_address),
                       32'(want.chunk_sound_address));
         compare_field("chunk_host_address", got.chunk_host_address, want.chunk_host_address);
         compare_field("hit_core0", 32'(got.hit_core0), 32'(want.hit_core0));
         compare_field("hit_core1", 32'(got.hit_core1), 32'(want.hit_core1));
         compare_field("channel_irq", 32'(got.channel_irq), 32'(want.channel_irq));
         compare_field("complete_flag", 32'(got.complete_flag), 32'(want.complete_flag));
         compare_field("busy_flag", 32'(got.busy_flag), 32'(want.busy_flag));
         compare_field("request_active", 32'(got.request_active), 32'(want.request_active));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [APB_ADDR_W-1:0] csr_paddr = '0;
   logic [APB_DATA_W-1:0] csr_pwdata = '0;
   logic [APB_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  calm = 1'b0;
   int                    cycle_count = 0;
   chunk_tracker_type     tracker;

   cdma_req_if req_if();
   cdma_rsp_if rsp_if();

   chunked_dma_channel #(
      .CHUNK_WORDS(CHUNK_WORDS),
      .CHUNK_DELAY(CHUNK_DELAY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .psel(csr_psel),
      .penable(csr_penable),
      .pwrite(csr_pwrite),
      .paddr(csr_paddr),
      .pwdata(csr_pwdata),
      .prdata(csr_prdata),
      .pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      cdma_pkg::result_type seen;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen.chunk_valid = rsp_if.chunk_valid;
         seen.chunk_direction = rsp_if.chunk_direction;
         seen.chunk_sound_address = rsp_if.chunk_sound_address;
         seen.chunk_host_address = rsp_if.chunk_host_address;
         seen.hit_core0 = rsp_if.hit_core0;
         seen.hit_core1 = rsp_if.hit_core1;
         seen.channel_irq = rsp_if.channel_irq;
         seen.complete_flag = rsp_if.complete_flag;
         seen.busy_flag = rsp_if.busy_flag;
         seen.request_active = rsp_if.request_active;
         tracker.check_result(seen);
      end
   end

   // stall the result side in bursts, with long stretches of ready
   initial begin : result_stall
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(20, 60)) @(negedge clock);
         else
            repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   task write_register(logic [1:0] index, logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.set_register(index, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task apply_settings(logic en0, logic [SOUND_W-1:0] addr0, logic en1,
                       logic [SOUND_W-1:0] addr1);
      write_register(cdma_pkg::REG_IRQ_ENABLE_CORE0, 32'(en0));
      write_register(cdma_pkg::REG_IRQ_ADDRESS_CORE0, 32'(addr0));
      write_register(cdma_pkg::REG_IRQ_ENABLE_CORE1, 32'(en1));
      write_register(cdma_pkg::REG_IRQ_ADDRESS_CORE1, 32'(addr1));
   endtask

   // call at a falling edge; valid stays high afterwards until the next call or a drain
   task send_beat(dma_beat_type b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.operation = b.operation;
      req_if.transfer_direction = b.transfer_direction;
      req_if.host_address = b.host_address;
      req_if.word_count = b.word_count;
      req_if.sound_start_address = b.sound_start_address;
      req_if.elapsed_cycles = b.elapsed_cycles;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_beat(b);
      @(negedge clock);
   endtask

   task drain();
      req_if.valid = 1'b0;
      while (tracker.expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic dma_beat_type make_beat(logic op, logic dir, logic [HOST_W-1:0] host,
                                              logic [COUNT_W-1:0] count,
                                              logic [SOUND_W-1:0] snd,
                                              logic [ELAPSED_W-1:0] elapsed);
      dma_beat_type b;
      b.operation = op;
      b.transfer_direction = dir;
      b.host_address = host;
      b.word_count = count;
      b.sound_start_address = snd;
      b.elapsed_cycles = elapsed;
      return b;
   endfunction

   function automatic dma_beat_type random_start();
      dma_beat_type b;
      b = make_beat(cdma_pkg::OP_START, 1'($urandom_range(0, 1)), $urandom, '0,
                    SOUND_W'($urandom), ELAPSED_W'($urandom));
      case ($urandom_range(0, 4))
         0: b.word_count = COUNT_W'($urandom);
         1: b.word_count = COUNT_W'($urandom_range(0, 3));
         default: b.word_count = COUNT_W'($urandom_range(1, 160));
      endcase
      // aim the transfer at a watched address so the hit windows get exercised
      case ($urandom_range(0, 3))
         0: b.sound_start_address = tracker.irq_addr0 - SOUND_W'($urandom_range(0, 100));
         1: b.sound_start_address = tracker.irq_addr1 - SOUND_W'($urandom_range(0, 100));
         default: ;
      endcase
      return b;
   endfunction

   function automatic dma_beat_type random_tick();
      dma_beat_type b;
      b = make_beat(cdma_pkg::OP_TICK, 1'($urandom_range(0, 1)), $urandom, COUNT_W'($urandom),
                    SOUND_W'($urandom), '0);
      case ($urandom_range(0, 9))
         0: b.elapsed_cycles = '0;
         1: b.elapsed_cycles = ELAPSED_W'(CHUNK_DELAY);
         2: b.elapsed_cycles = ELAPSED_W'(CHUNK_DELAY - 1);
         3: b.elapsed_cycles = ELAPSED_W'($urandom);
         4: b.elapsed_cycles = ELAPSED_W'($urandom_range(0, 50));
         default: b.elapsed_cycles = ELAPSED_W'($urandom_range(200, 1600));
      endcase
      return b;
   endfunction

   initial begin : stimulus
      int phase;
      int sent;
      int ticks;
      tracker = new();
      req_if.valid = 1'b0;
      req_if.operation = cdma_pkg::OP_TICK;
      req_if.transfer_direction = 1'b0;
      req_if.host_address = '0;
      req_if.word_count = '0;
      req_if.sound_start_address = '0;
      req_if.elapsed_cycles = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_settings(1'b1, 20'h00010, 1'b1, 20'hfffff);
      // tick while idle, then a zero count start that completes at once
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'hffffff));
      send_beat(make_beat(cdma_pkg::OP_START, 1'b1, 32'hffffffff, '0, 20'hfffff, 24'hffffff));
      // chunk at the top of sound memory: no wrap into the low window, host wraps
      send_beat(make_beat(cdma_pkg::OP_START, 1'b0, 32'hffffffc0, 24'd33, 20'hfffe0, '0));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b1, '0, '0, '0, '0));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'(CHUNK_DELAY - 1)));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'd1));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'hffffff));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'd7));
      send_beat(make_beat(cdma_pkg::OP_START, 1'b1, 32'h12345678, 24'hffffff, 20'h00000, '0));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'hffffff));
      // start while busy replaces the running transfer
      send_beat(make_beat(cdma_pkg::OP_START, 1'b0, 32'haaaaaaaa, 24'd32, 20'hfffff,
                          24'h555555));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'd5));
      send_beat(make_beat(cdma_pkg::OP_START, 1'b0, 32'h55555555, 24'd64, 20'h55555, '0));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'(CHUNK_DELAY)));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, '0));
      send_beat(make_beat(cdma_pkg::OP_TICK, 1'b0, '0, '0, '0, 24'(CHUNK_DELAY)));
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_settings(1'b0, '0, 1'b0, '0);
            1: apply_settings(1'b1, 20'hfffff, 1'b1, 20'hfffff);
            2: apply_settings(1'b1, '0, 1'b0, 20'h80000);
            default: apply_settings(1'($urandom_range(0, 1)), SOUND_W'($urandom),
                                    1'($urandom_range(0, 1)), SOUND_W'($urandom));
         endcase
         if (phase == PHASES - 1)
            calm = 1'b1;
         sent = 0;
         while (sent < PHASE_BEATS) begin
            // mostly a start followed by ticks; a tick burst alone is noise
            if ($urandom_range(0, 9) != 0) begin
               send_beat(random_start());
               sent++;
            end
            ticks = $urandom_range(0, 12);
            repeat (ticks) send_beat(random_tick());
            sent += ticks;
            if (phase == 2 && sent >= 50 && sent < 65)
               drain();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
